// File: src/cpe_pkg.sv
// Shared types for the windowed energy sum: controller states and datapath commands.
package cpe_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_SUM,
    ST_MULT,
    ST_READ,
    ST_UPDATE
  } state_t;

  // Commands from the controller to the datapath, one strobe per step.
  typedef struct packed {
    logic load_in;
    logic do_square;
    logic do_sum;
    logic do_mult;
    logic do_read;
    logic do_update;
  } cmd_t;

endpackage

// File: src/cpe_ctrl.sv
// Controller state machine that sequences one word through the datapath.
module cpe_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  output cpe_pkg::cmd_t cmd
);

  cpe_pkg::state_t state;
  cpe_pkg::state_t state_next;
  logic            out_valid_next;
  logic            commit;

  assign commit = (state == cpe_pkg::ST_UPDATE) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= cpe_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      cpe_pkg::ST_IDLE: begin
        if (in_valid) state_next = cpe_pkg::ST_SQUARE;
      end
      cpe_pkg::ST_SQUARE: state_next = cpe_pkg::ST_SUM;
      cpe_pkg::ST_SUM:    state_next = cpe_pkg::ST_MULT;
      cpe_pkg::ST_MULT:   state_next = cpe_pkg::ST_READ;
      cpe_pkg::ST_READ:   state_next = cpe_pkg::ST_UPDATE;
      cpe_pkg::ST_UPDATE: begin
        if (commit) state_next = cpe_pkg::ST_IDLE;
      end
      default: state_next = cpe_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall       = (state != cpe_pkg::ST_IDLE);
    cmd            = '0;
    cmd.load_in    = (state == cpe_pkg::ST_IDLE) && in_valid;
    cmd.do_square  = (state == cpe_pkg::ST_SQUARE);
    cmd.do_sum     = (state == cpe_pkg::ST_SUM);
    cmd.do_mult    = (state == cpe_pkg::ST_MULT);
    cmd.do_read    = (state == cpe_pkg::ST_READ);
    cmd.do_update  = commit;
    out_valid_next = commit | (out_valid & out_stall);
  end

endmodule

// File: src/cpe_datapath.sv
// Datapath: squares, magnitude sum, rho scaling, energy window memory and running total.
module cpe_datapath #(
  parameter int WINDOW_LEN = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  cpe_pkg::cmd_t      cmd,
  input  logic               cfg_wr_en,
  input  logic        [15:0] cfg_wr_data,
  input  logic               sample_valid,
  input  logic signed [15:0] cur_real,
  input  logic signed [15:0] cur_imag,
  input  logic signed [15:0] lag_real,
  input  logic signed [15:0] lag_imag,
  output logic        [34:0] window_sum,
  output logic               sum_valid
);

  localparam int PosW = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int CntW = $clog2(WINDOW_LEN + 1);

  logic        [15:0] rho;
  logic               smp_valid;
  logic signed [15:0] cr, ci, lr, li;
  logic signed [31:0] prod_cr, prod_ci, prod_lr, prod_li;
  logic        [30:0] sq_cr, sq_ci, sq_lr, sq_li;
  logic        [32:0] mag;
  logic        [48:0] scaled;
  logic        [30:0] term;
  logic        [30:0] leave_data;
  logic               leave_ok;
  logic        [30:0] leaving;
  logic        [34:0] total;
  logic        [34:0] total_next;
  logic        [CntW-1:0] fill;
  logic        [CntW-1:0] fill_next;
  logic        [PosW-1:0] pos;
  logic        [30:0] window_mem [WINDOW_LEN];
  logic        [WINDOW_LEN-1:0] entry_ok;

  assign prod_cr = 32'(cr) * 32'(cr);
  assign prod_ci = 32'(ci) * 32'(ci);
  assign prod_lr = 32'(lr) * 32'(lr);
  assign prod_li = 32'(li) * 32'(li);
  assign scaled  = {33'd0, rho} * {16'd0, mag};
  assign leaving = leave_ok ? leave_data : 31'd0;

  always_comb begin
    total_next = total + {4'd0, term} - {4'd0, leaving};
    if (!smp_valid) begin
      fill_next = '0;
    end else if (fill < CntW'(WINDOW_LEN)) begin
      fill_next = fill + CntW'(1);
    end else begin
      fill_next = fill;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rho <= '0;
    end else if (cfg_wr_en) begin
      rho <= cfg_wr_data;
    end
  end

  // Pipeline payload, stepped by the controller.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      smp_valid <= sample_valid;
      cr        <= cur_real;
      ci        <= cur_imag;
      lr        <= lag_real;
      li        <= lag_imag;
    end
    if (cmd.do_square) begin
      sq_cr <= prod_cr[30:0];
      sq_ci <= prod_ci[30:0];
      sq_lr <= prod_lr[30:0];
      sq_li <= prod_li[30:0];
    end
    if (cmd.do_sum) begin
      mag <= {2'd0, sq_cr} + {2'd0, sq_ci} + {2'd0, sq_lr} + {2'd0, sq_li};
    end
    if (cmd.do_mult) begin
      term <= smp_valid ? scaled[47:17] : 31'd0;
    end
    if (cmd.do_read) begin
      leave_data <= window_mem[pos];
      leave_ok   <= entry_ok[pos];
    end
    if (cmd.do_update) begin
      window_mem[pos] <= term;
      window_sum      <= total_next;
      sum_valid       <= (fill_next == CntW'(WINDOW_LEN));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total    <= '0;
      fill     <= '0;
      pos      <= '0;
      entry_ok <= '0;
    end else if (cmd.do_update) begin
      total         <= total_next;
      fill          <= fill_next;
      entry_ok[pos] <= 1'b1;
      if (pos == PosW'(WINDOW_LEN - 1)) begin
        pos <= '0;
      end else begin
        pos <= pos + PosW'(1);
      end
    end
  end

endmodule

// File: src/cp_energy_moving_sum_top.sv
// Top level of the cyclic-prefix energy moving sum: controller plus datapath.
// The controller walks each word through the square, sum, multiply, window read and
// update steps on one shared datapath, and takes no new word until the last is through.
// A stalled result holds the update step until the output register frees.
// Reset (rst, synchronous, active high) clears rho, the running total, the fill count and
// the window entry flags at once, so the window reads as all zero with no clearing pass.
module cp_energy_moving_sum_top #(
  parameter int WINDOW_LEN = 16
) (
  input  logic               clk,
  input  logic               rst,
  // Configuration write of rho in unsigned Q0.16.
  input  logic               cfg_wr_en,
  input  logic        [15:0] cfg_wr_data,
  // Input word channel.
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               sample_valid,
  input  logic signed [15:0] cur_real,
  input  logic signed [15:0] cur_imag,
  input  logic signed [15:0] lag_real,
  input  logic signed [15:0] lag_imag,
  // Result word channel.
  output logic               out_valid,
  input  logic               out_stall,
  output logic        [34:0] window_sum,
  output logic               sum_valid
);

  cpe_pkg::cmd_t cmd;

  // The controller only sequences; all arithmetic and the data state sit in the datapath.
  cpe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // The energy term is (rho * sum of four squares) >> 17, and the window total adds
  // the new term and drops the oldest one, wrapping at 35 bits.
  cpe_datapath #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .sample_valid (sample_valid),
    .cur_real     (cur_real),
    .cur_imag     (cur_imag),
    .lag_real     (lag_real),
    .lag_imag     (lag_imag),
    .window_sum   (window_sum),
    .sum_valid    (sum_valid)
  );

endmodule
